// ===== rtl/core/bcat_pkg.sv =====
// Shared widths, command and status codes, and defaults for the block allocation map.
`timescale 1ns / 1ps

package bcat_pkg;

    // Default number of map entries held in the storage.
    localparam int DEFAULT_MAP_ENTRIES = 4096;

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int LINK_W   = 24;
    localparam int KIND_W   = 8;
    localparam int STATUS_W = 2;
    localparam int DISK_W   = 13;

    // Register value after reset.
    localparam logic [DISK_W-1:0] DISK_BLOCKS_RESET = 13'd4096;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 3'd0,
        CMD_LINK  = 3'd1,
        CMD_NEXT  = 3'd2,
        CMD_FREE  = 3'd3,
        CMD_WRITE = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_END  = 2'd1,
        ST_FULL = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

endpackage

// ===== rtl/core/bcat_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/block_chain_allocation_table.sv =====
// Top level of the block allocation map: command sequencer around the type and link memories.
`timescale 1ns / 1ps

// Channel   Dir  Signals                    Contents (lowest bit first)
// s_        in   tvalid tready tdata tuser  tdata: index[23:0] target[47:24] entry_type[55:48]
//                                           tuser: cmd[2:0]
// m_        out  tvalid tready tdata tuser  tdata: value[23:0] type_read[31:24]
//                                           freed_count[44:32], zero fill [47:45]
//                                           tuser: status[1:0]
// cfg_      in   wr_en wr_data              disk_blocks[12:0]
//
// One request is worked on at a time. Link, write and rejected requests are settled on
// acceptance; next and read wait for a memory read; alloc scans up from entry 0 (one
// memory read per cycle) to the first free entry; free empties the chain entry by entry.
// After reset a clearing pass writes every entry with s_tready low.
// The result register lets a new request enter while the previous result waits.

module block_chain_allocation_table
    import bcat_pkg::*;
#(
    parameter int MAP_ENTRIES = DEFAULT_MAP_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [55:0]         s_tdata,   // index, target, entry_type
    input  logic [CMD_W-1:0]    s_tuser,   // cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // value, type_read, freed_count, zero fill
    output logic [STATUS_W-1:0] m_tuser,   // status
    input  logic                cfg_wr_en,
    input  logic [DISK_W-1:0]   cfg_wr_data
);

    localparam int AW = $clog2(MAP_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_NEXT_RD,
        S_READ_RD,
        S_FREE_HEAD,
        S_FREE_CHK,
        S_FREE_RD,
        S_RESP
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_reg;
    logic [DISK_W-1:0]   disk_reg;
    logic [LINK_W-1:0]   idx_reg;
    logic [KIND_W-1:0]   typ_reg;
    logic [DISK_W-1:0]   scan_reg;
    logic                pend_reg;
    logic [DISK_W-1:0]   pend_addr_reg;
    logic [LINK_W-1:0]   walk_reg;
    logic [DISK_W-1:0]   cnt_reg;
    status_t             res_status_reg;
    logic [LINK_W-1:0]   res_value_reg;
    logic [KIND_W-1:0]   res_type_reg;
    logic [DISK_W-1:0]   res_freed_reg;
    logic                m_tvalid_reg;
    status_t             m_status_reg;
    logic [LINK_W-1:0]   m_value_reg;
    logic [KIND_W-1:0]   m_type_reg;
    logic [DISK_W-1:0]   m_freed_reg;

    logic [LINK_W-1:0]   in_index;
    logic [LINK_W-1:0]   in_target;
    logic [KIND_W-1:0]   in_type;
    cmd_t                in_cmd;
    logic [DISK_W-1:0]   lim;
    logic                in_idx_ok;
    logic                walk_ok;
    logic                accept;
    logic                found;

    logic                kind_we;
    logic                next_we;
    logic [AW-1:0]       waddr;
    logic [KIND_W-1:0]   kind_wdata;
    logic [LINK_W-1:0]   next_wdata;
    logic [AW-1:0]       raddr;
    logic [KIND_W-1:0]   kind_rdata;
    logic [LINK_W-1:0]   next_rdata;

    // Unpack the request.
    assign in_index  = s_tdata[23:0];
    assign in_target = s_tdata[47:24];
    assign in_type   = s_tdata[55:48];
    assign in_cmd    = cmd_t'(s_tuser);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Entries in use are the smaller of the register and the storage depth.
    always_comb begin
        if (25'(disk_reg) < 25'(MAP_ENTRIES)) begin
            lim = disk_reg;
        end else begin
            lim = DISK_W'(MAP_ENTRIES);
        end
    end

    assign in_idx_ok = in_index < LINK_W'(lim);
    assign walk_ok   = walk_reg < LINK_W'(lim);
    assign found     = pend_reg && (kind_rdata == '0);

    // Memory port control.
    always_comb begin
        kind_we    = 1'b0;
        next_we    = 1'b0;
        waddr      = AW'(idx_reg);
        kind_wdata = '0;
        next_wdata = '0;
        unique case (state_reg)
            S_CLEAR: begin
                kind_we = 1'b1;
                next_we = 1'b1;
                waddr   = clr_reg;
            end
            S_IDLE: begin
                waddr      = AW'(in_index);
                kind_wdata = in_type;
                next_wdata = in_target;
                if (accept && in_idx_ok && in_cmd == CMD_LINK) begin
                    next_we = 1'b1;
                end
                if (accept && in_idx_ok && in_cmd == CMD_WRITE) begin
                    kind_we = 1'b1;
                    next_we = 1'b1;
                end
            end
            S_ALLOC: begin
                waddr      = AW'(pend_addr_reg);
                kind_wdata = typ_reg;
                kind_we    = found;
                next_we    = found;
            end
            S_FREE_HEAD: begin
                next_we = 1'b1;
            end
            S_FREE_RD: begin
                waddr   = AW'(walk_reg);
                kind_we = 1'b1;
                next_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_IDLE:     raddr = AW'(in_index);
            S_ALLOC:    raddr = AW'(scan_reg);
            S_FREE_CHK: raddr = AW'(walk_reg);
            default:    raddr = AW'(idx_reg);
        endcase
    end

    bcat_ram #(
        .WIDTH (KIND_W),
        .DEPTH (MAP_ENTRIES)
    ) u_kind_ram (
        .aclk  (aclk),
        .we    (kind_we),
        .waddr (waddr),
        .wdata (kind_wdata),
        .raddr (raddr),
        .rdata (kind_rdata)
    );

    bcat_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAP_ENTRIES)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (waddr),
        .wdata (next_wdata),
        .raddr (raddr),
        .rdata (next_rdata)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_reg <= DISK_BLOCKS_RESET;
        end else if (cfg_wr_en) begin
            disk_reg <= cfg_wr_data;
        end
    end

    // Command sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Zero every entry once after reset.
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MAP_ENTRIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end

                // Take a request and settle the one-step cases here.
                S_IDLE: begin
                    if (accept) begin
                        idx_reg        <= in_index;
                        typ_reg        <= in_type;
                        res_status_reg <= ST_BAD;
                        res_value_reg  <= '0;
                        res_type_reg   <= '0;
                        res_freed_reg  <= '0;
                        scan_reg       <= '0;
                        pend_reg       <= 1'b0;
                        cnt_reg        <= '0;
                        state_reg      <= S_RESP;
                        unique case (in_cmd)
                            CMD_ALLOC: begin
                                state_reg <= S_ALLOC;
                            end
                            CMD_LINK, CMD_WRITE: begin
                                if (in_idx_ok) begin
                                    res_status_reg <= ST_OK;
                                end
                            end
                            CMD_NEXT: begin
                                if (in_index == '0 || !in_idx_ok) begin
                                    res_status_reg <= ST_END;
                                end else begin
                                    state_reg <= S_NEXT_RD;
                                end
                            end
                            CMD_FREE: begin
                                if (in_idx_ok) begin
                                    state_reg <= S_FREE_HEAD;
                                end
                            end
                            CMD_READ: begin
                                if (in_idx_ok) begin
                                    state_reg <= S_READ_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // First-fit search: one read issued per cycle, each checked once its registered read data returns.
                S_ALLOC: begin
                    if (found) begin
                        res_status_reg <= ST_OK;
                        res_value_reg  <= LINK_W'(pend_addr_reg);
                        state_reg      <= S_RESP;
                    end else if (scan_reg >= lim) begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_RESP;
                    end else begin
                        scan_reg      <= scan_reg + 1'b1;
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= scan_reg;
                    end
                end

                S_NEXT_RD: begin
                    if (next_rdata == '0) begin
                        res_status_reg <= ST_END;
                    end else begin
                        res_status_reg <= ST_OK;
                        res_value_reg  <= next_rdata;
                    end
                    state_reg <= S_RESP;
                end

                S_READ_RD: begin
                    res_status_reg <= ST_OK;
                    res_value_reg  <= next_rdata;
                    res_type_reg   <= kind_rdata;
                    state_reg      <= S_RESP;
                end

                // Head link is read; it is cleared in this cycle.
                S_FREE_HEAD: begin
                    walk_reg  <= next_rdata;
                    state_reg <= S_FREE_CHK;
                end

                // Decide whether the walk goes on; the read of the next entry is issued here.
                S_FREE_CHK: begin
                    if (walk_reg == '0) begin
                        res_status_reg <= ST_OK;
                        res_freed_reg  <= cnt_reg;
                        state_reg      <= S_RESP;
                    end else if (!walk_ok || cnt_reg >= lim) begin
                        res_status_reg <= ST_BAD;
                        res_freed_reg  <= cnt_reg;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_FREE_RD;
                    end
                end

                // The entry is emptied in this cycle; follow its old link.
                S_FREE_RD: begin
                    walk_reg  <= next_rdata;
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_FREE_CHK;
                end

                // Hand the result over once the output register is free.
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                        m_type_reg   <= res_type_reg;
                        m_freed_reg  <= res_freed_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output packing.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_freed_reg, m_type_reg, m_value_reg};

endmodule

// ===== test/tb_block_chain_allocation_table.sv =====
// Self-checking testbench for the block allocation map: directed and random requests.
`timescale 1ns / 1ps

module tb_block_chain_allocation_table;
    import bcat_pkg::*;

    localparam int          MAP_DEPTH      = DEFAULT_MAP_ENTRIES;
    localparam time         HALF_PERIOD    = 6ns;
    localparam int          WATCHDOG_LIMIT = 40000;
    localparam int          LONG_HOLD      = 300;
    localparam int          SETTLE_CYCLES  = 16;
    localparam logic [12:0] FREED_MAX      = 13'h1fff;

    // Command codes the block does not define; both must be rejected.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LINK_W-1:0] index;
        logic [LINK_W-1:0] target;
        logic [KIND_W-1:0] etype;
    } map_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LINK_W-1:0]   value;
        logic [KIND_W-1:0]   kind;
        logic [DISK_W-1:0]   freed;
    } map_result_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [55:0]         s_tdata     = '0;  // index, target, entry_type
    logic [CMD_W-1:0]    s_tuser     = '0;  // cmd
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [47:0]         m_tdata;           // value, type_read, freed_count, zero fill
    logic [STATUS_W-1:0] m_tuser;           // status
    logic                cfg_wr_en   = 1'b0;
    logic [DISK_W-1:0]   cfg_wr_data = '0;

    // Shadow copy of the map and its size register.
    logic [KIND_W-1:0] map_kind [MAP_DEPTH];
    logic [LINK_W-1:0] map_link [MAP_DEPTH];
    int unsigned       map_size;

    map_req_t    pending_q [$];
    map_result_t result_q  [$];
    map_req_t    bus_req;

    int tx_gap       = 0;
    int rx_wait      = 0;
    int stall_cycles = 0;
    int errors       = 0;
    bit quiet        = 1'b0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    block_chain_allocation_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic int unsigned active_entries();
        return (map_size < MAP_DEPTH) ? map_size : MAP_DEPTH;
    endfunction

    // Runs one request against the shadow map and returns the result it must produce.
    function automatic map_result_t run_map_command(map_req_t rq);
        map_result_t r;
        int unsigned lim, i, walk, cur, steps;
        lim      = active_entries();
        r.status = ST_BAD;
        r.value  = '0;
        r.kind   = '0;
        r.freed  = '0;
        case (rq.cmd)
            CMD_ALLOC: begin
                r.status = ST_FULL;
                for (i = 0; i < lim; i++) begin
                    if (map_kind[i] == '0) begin
                        map_kind[i] = rq.etype;
                        map_link[i] = '0;
                        r.status    = ST_OK;
                        r.value     = i[LINK_W-1:0];
                        break;
                    end
                end
            end
            CMD_LINK: begin
                if (rq.index < lim) begin
                    map_link[rq.index] = rq.target;
                    r.status           = ST_OK;
                end
            end
            CMD_NEXT: begin
                if (rq.index == '0 || rq.index >= lim || map_link[rq.index] == '0) begin
                    r.status = ST_END;
                end else begin
                    r.status = ST_OK;
                    r.value  = map_link[rq.index];
                end
            end
            CMD_FREE: begin
                if (rq.index < lim) begin
                    // Cut the chain after the start entry, then empty what followed it.
                    walk               = map_link[rq.index];
                    map_link[rq.index] = '0;
                    steps              = 0;
                    r.status           = ST_OK;
                    while (walk != 0) begin
                        if (walk >= lim || steps >= lim) begin
                            r.status = ST_BAD;
                            break;
                        end
                        cur           = walk;
                        walk          = map_link[cur];
                        map_link[cur] = '0;
                        map_kind[cur] = '0;
                        steps++;
                        if (r.freed < FREED_MAX)
                            r.freed = r.freed + 1'b1;
                    end
                end
            end
            CMD_WRITE: begin
                if (rq.index < lim) begin
                    map_kind[rq.index] = rq.etype;
                    map_link[rq.index] = rq.target;
                    r.status           = ST_OK;
                end
            end
            CMD_READ: begin
                if (rq.index < lim) begin
                    r.value  = map_link[rq.index];
                    r.kind   = map_kind[rq.index];
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_req(int unsigned c, int unsigned idx, int unsigned tgt, int unsigned typ);
        map_req_t rq;
        rq.cmd    = c[CMD_W-1:0];
        rq.index  = idx[LINK_W-1:0];
        rq.target = tgt[LINK_W-1:0];
        rq.etype  = typ[KIND_W-1:0];
        pending_q.push_back(rq);
    endtask

    // Mostly valid entries, some just past the end, some anywhere in the 24-bit space.
    function automatic int unsigned rand_index(int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (lim > 0 && r < 15)
            return $urandom_range(0, lim - 1);
        else if (r < 17)
            return lim;
        return $urandom();
    endfunction

    function automatic int unsigned rand_target(int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 0;
        else if (lim > 0 && r < 14)
            return $urandom_range(0, lim - 1);
        return $urandom();
    endfunction

    // Random mix: mostly chains built and then walked and freed, plus allocs and noise.
    task automatic add_random_reqs(int unsigned count);
        int unsigned added, lim, pick, n, k;
        int unsigned chain [4];
        added = 0;
        lim   = active_entries();
        while (added < count) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5 && lim >= 2) begin
                n = $urandom_range(1, (lim - 1 < 4) ? lim - 1 : 4);
                for (k = 0; k < n; k++)
                    chain[k] = $urandom_range(1, lim - 1);
                for (k = 0; k < n; k++)
                    add_req(CMD_WRITE, chain[k], (k + 1 < n) ? chain[k + 1] : 0,
                            $urandom_range(1, 255));
                add_req(CMD_NEXT, chain[$urandom_range(0, n - 1)], $urandom(), $urandom());
                add_req(CMD_READ, chain[$urandom_range(0, n - 1)], $urandom(), $urandom());
                if ($urandom_range(0, 1) == 1)
                    add_req(CMD_LINK, chain[n - 1], rand_target(lim), $urandom());
                add_req(CMD_FREE, chain[$urandom_range(0, n - 1)], $urandom(), $urandom());
                added += n + 4;
            end else if (pick <= 7) begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    add_req(CMD_ALLOC, $urandom(), $urandom(), $urandom());
                added += n;
            end else begin
                add_req($urandom_range(0, 7), rand_index(lim), rand_target(lim), $urandom());
                added++;
            end
        end
    endtask

    task automatic write_disk_blocks(logic [DISK_W-1:0] blocks);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= blocks;
        map_size     = blocks;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Waits until every request has been taken and every result checked.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_q.size() > 0 || s_tvalid || result_q.size() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(logic [DISK_W-1:0] blocks, int unsigned count, bit no_idle,
                             bit long_hold);
        write_disk_blocks(blocks);
        @(negedge aclk);
        quiet    = no_idle;
        hold_req = long_hold;
        add_random_reqs(count);
        wait_drained();
    endtask

    task automatic check_field(string name, logic [LINK_W-1:0] want, logic [LINK_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Driver: presents queued requests with a random gap after each one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                result_q.push_back(run_map_command(bus_req));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (pending_q.size() > 0) begin
                    bus_req   = pending_q.pop_front();
                    s_tdata  <= {bus_req.etype, bus_req.target, bus_req.index};
                    s_tuser  <= bus_req.cmd;
                    s_tvalid <= 1'b1;
                    tx_gap   <= quiet ? 0 : $urandom_range(0, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result and stalls the result channel at random.
    always @(posedge aclk) begin : result_monitor
        int          hold;
        map_result_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_wait   <= 0;
            hold_done <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d, data 0x%0h", $time, m_tuser,
                         m_tdata);
            end else begin
                want = result_q.pop_front();
                check_field("status", LINK_W'(want.status), LINK_W'(m_tuser));
                check_field("value", want.value, m_tdata[23:0]);
                check_field("type_read", LINK_W'(want.kind), LINK_W'(m_tdata[31:24]));
                check_field("freed_count", LINK_W'(want.freed), LINK_W'(m_tdata[44:32]));
            end
            // One long hold lets the block fill up and push back on its input.
            if (hold_req && !hold_done) begin
                hold      = LONG_HOLD;
                hold_done <= 1'b1;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 7);
            end
            m_tready <= (hold == 0);
            rx_wait  <= (hold > 0) ? hold - 1 : 0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run if work is outstanding and nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_q.size() == 0 && !s_tvalid && result_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL block_chain_allocation_table");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned e;
        for (e = 0; e < MAP_DEPTH; e++) begin
            map_kind[e] = '0;
            map_link[e] = '0;
        end
        map_size = DISK_BLOCKS_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        write_disk_blocks(13'd4096);
        @(negedge aclk);
        // First-fit alloc, including a type of zero that leaves the entry empty.
        add_req(CMD_READ, 0, 0, 0);
        add_req(CMD_ALLOC, 0, 0, 8'hff);
        add_req(CMD_ALLOC, 24'hffffff, 24'hffffff, 8'h00);
        add_req(CMD_ALLOC, 0, 0, 8'h01);
        // Last entry holding the largest link, and next at the edges of the map.
        add_req(CMD_WRITE, 4095, 24'hffffff, 8'h80);
        add_req(CMD_READ, 4095, 0, 0);
        add_req(CMD_NEXT, 4095, 0, 0);
        add_req(CMD_NEXT, 0, 0, 0);
        add_req(CMD_NEXT, 4096, 0, 0);
        add_req(CMD_LINK, 4096, 7, 0);
        // Chain 0 -> 2 -> 3, walked and then freed after entry 0.
        add_req(CMD_WRITE, 2, 3, 8'h03);
        add_req(CMD_WRITE, 3, 0, 8'h7f);
        add_req(CMD_LINK, 0, 2, 0);
        add_req(CMD_NEXT, 2, 0, 0);
        add_req(CMD_NEXT, 3, 0, 0);
        add_req(CMD_FREE, 0, 0, 0);
        add_req(CMD_READ, 2, 0, 0);
        // Free walk that runs into an out-of-range link.
        add_req(CMD_FREE, 4095, 0, 0);
        // Cycle that leads back to the start entry, which gets emptied too.
        add_req(CMD_WRITE, 5, 6, 8'h55);
        add_req(CMD_WRITE, 6, 5, 8'haa);
        add_req(CMD_FREE, 5, 0, 0);
        add_req(CMD_READ, 5, 0, 0);
        add_req(CMD_READ, 24'hffffff, 0, 0);
        add_req(CMD_SPARE_A, 24'hffffff, 24'hffffff, 8'hff);
        add_req(CMD_SPARE_B, 1, 1, 1);
        add_random_reqs(10);
        wait_drained();

        run_phase(13'd16, 24, 1'b0, 1'b1);
        run_phase(13'd2, 12, 1'b0, 1'b0);
        run_phase(13'd8191, 16, 1'b1, 1'b0);
        run_phase(13'd0, 8, 1'b0, 1'b0);
        run_phase(13'd37, 18, 1'b1, 1'b0);
        run_phase(13'd4096, 10, 1'b0, 1'b0);

        if (errors == 0 && result_q.size() == 0) begin
            $display("PASS block_chain_allocation_table");
        end else begin
            $display("FAIL block_chain_allocation_table");
        end
        $finish;
    end

endmodule
